// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PATTERN     = 16;
    localparam int MAX_REPLACEMENT = 16;

    // held store index and count widths
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    // APB port widths: six 64-bit registers at 8*i
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    typedef logic [7:0]       t_byte;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [2:0]       t_reg_idx;

    // register indexes
    localparam t_reg_idx REG_PLEN = 3'd0;
    localparam t_reg_idx REG_RLEN = 3'd1;
    localparam t_reg_idx REG_PLO  = 3'd2;
    localparam t_reg_idx REG_PHI  = 3'd3;
    localparam t_reg_idx REG_RLO  = 3'd4;
    localparam t_reg_idx REG_RHI  = 3'd5;

    // effective configuration seen by the sequencer
    typedef struct packed {
        t_cnt                             plen;
        t_cnt                             rlen;
        logic [MAX_PATTERN-1:0][7:0]      pat;
        logic [MAX_REPLACEMENT-1:0][7:0]  rep;
    } t_cfg;

    // sequencer to result stage
    typedef struct packed {
        logic  push;     // wants to hand over one result byte
        logic  fin;      // end of the input transaction
        logic  last;     // input transaction carried content_last
        t_byte data;
        logic  valid;
    } t_emit_req;

    // result stage to sequencer
    typedef struct packed {
        logic can_push;
        logic can_fin;
    } t_emit_sts;

endpackage

// File: rtl/sfr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_in_if
// Content byte channel: valid/ready handshake with data byte and last flag.
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       content_last;

    modport source (output valid, output data_byte, output content_last, input ready);
    modport sink   (input valid, input data_byte, input content_last, output ready);
endinterface

// File: rtl/sfr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_if
// Result channel: valid/ready handshake with rewritten byte and end flags.
// ----------------------------------------------------------------------------
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output byte_valid,
                    output run_last, output stream_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input run_last, input stream_end, output ready);
endinterface

// File: rtl/sfr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_regs
// APB configuration registers; derives effective lengths and flags writes.
// ----------------------------------------------------------------------------
module sfr_regs import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output logic              o_clear
);

    logic [4:0]        r_plen;
    logic [4:0]        r_rlen;
    logic [63:0]       r_plo;
    logic [63:0]       r_phi;
    logic [63:0]       r_rlo;
    logic [63:0]       r_rhi;
    logic              wr;
    t_reg_idx          sel;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign sel    = paddr[APB_AW-1:3];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= 5'd1;
            r_rlen <= 5'd0;
            r_plo  <= '0;
            r_phi  <= '0;
            r_rlo  <= '0;
            r_rhi  <= '0;
        end else if (wr) begin
            case (sel)
                REG_PLEN: r_plen <= pwdata[4:0];
                REG_RLEN: r_rlen <= pwdata[4:0];
                REG_PLO:  r_plo  <= pwdata;
                REG_PHI:  r_phi  <= pwdata;
                REG_RLO:  r_rlo  <= pwdata;
                REG_RHI:  r_rhi  <= pwdata;
                default: ;
            endcase
        end
    end

    // any write to a defined register drops the held partial match
    always_comb begin
        o_clear = 1'b0;
        if (wr) begin
            case (sel)
                REG_PLEN, REG_RLEN, REG_PLO, REG_PHI, REG_RLO, REG_RHI: o_clear = 1'b1;
                default: o_clear = 1'b0;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (sel)
            REG_PLEN: prdata = {{(APB_DW-5){1'b0}}, r_plen};
            REG_RLEN: prdata = {{(APB_DW-5){1'b0}}, r_rlen};
            REG_PLO:  prdata = r_plo;
            REG_PHI:  prdata = r_phi;
            REG_RLO:  prdata = r_rlo;
            REG_RHI:  prdata = r_rhi;
            default:  prdata = '0;
        endcase
    end

    // effective lengths: empty pattern counts as one byte, both saturate
    always_comb begin
        if (r_plen == 5'd0)
            o_cfg.plen = CNT_W'(1);
        else if (r_plen > CNT_W'(MAX_PATTERN))
            o_cfg.plen = CNT_W'(MAX_PATTERN);
        else
            o_cfg.plen = r_plen;

        if (r_rlen > CNT_W'(MAX_REPLACEMENT))
            o_cfg.rlen = CNT_W'(MAX_REPLACEMENT);
        else
            o_cfg.rlen = r_rlen;

        o_cfg.pat = {r_phi, r_plo};
        o_cfg.rep = {r_rhi, r_rlo};
    end

endmodule

// File: rtl/sfr_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_emit
// Result stage: one-deep pending slot so the final byte of a transaction can
// be tagged run_last, followed by the output register.
// ----------------------------------------------------------------------------
module sfr_emit import sfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_emit_req i_req,
    output t_emit_sts o_sts,
    sfr_out_if.source o_out
);

    logic  r_pend_v, n_pend_v;
    t_byte r_pend_byte, n_pend_byte;
    logic  r_pend_bv, n_pend_bv;

    logic  r_ov, n_ov;
    t_byte r_obyte, n_obyte;
    logic  r_obv, n_obv;
    logic  r_orl, n_orl;
    logic  r_ose, n_ose;

    logic  out_free;

    assign out_free       = !r_ov || o_out.ready;
    assign o_sts.can_push = !r_pend_v || out_free;
    assign o_sts.can_fin  = out_free;

    always_comb begin
        n_pend_v    = r_pend_v;
        n_pend_byte = r_pend_byte;
        n_pend_bv   = r_pend_bv;
        n_ov        = r_ov;
        n_obyte     = r_obyte;
        n_obv       = r_obv;
        n_orl       = r_orl;
        n_ose       = r_ose;

        if (r_ov && o_out.ready)
            n_ov = 1'b0;

        // new byte: older pending byte moves to the output register
        if (i_req.push && o_sts.can_push) begin
            if (r_pend_v) begin
                n_ov    = 1'b1;
                n_obyte = r_pend_byte;
                n_obv   = r_pend_bv;
                n_orl   = 1'b0;
                n_ose   = 1'b0;
            end
            n_pend_v    = 1'b1;
            n_pend_byte = i_req.data;
            n_pend_bv   = i_req.valid;
        end

        // end of transaction: tag pending byte, or send the bare marker
        if (i_req.fin && out_free) begin
            if (r_pend_v) begin
                n_ov     = 1'b1;
                n_obyte  = r_pend_byte;
                n_obv    = r_pend_bv;
                n_orl    = 1'b1;
                n_ose    = i_req.last;
                n_pend_v = 1'b0;
            end else if (i_req.last) begin
                n_ov    = 1'b1;
                n_obyte = 8'h00;
                n_obv   = 1'b0;
                n_orl   = 1'b1;
                n_ose   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_byte <= n_pend_byte;
        r_pend_bv   <= n_pend_bv;
        r_obyte     <= n_obyte;
        r_obv       <= n_obv;
        r_orl       <= n_orl;
        r_ose       <= n_ose;
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_obyte;
    assign o_out.byte_valid = r_obv;
    assign o_out.run_last   = r_orl;
    assign o_out.stream_end = r_ose;

endmodule

// File: rtl/sfr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_seq
// Sequencer with the held-byte store and one shared byte comparator. Scans
// held bytes against the pattern one byte a cycle unless a release stalls,
// releases the front byte on a mismatch and rescans, replaces a full match.
// ----------------------------------------------------------------------------
module sfr_seq import sfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_clear,
    sfr_in_if.sink    i_in,
    output t_emit_req o_req,
    input  t_emit_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_REPL  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    t_cnt       r_idx, n_idx;
    logic       r_last, n_last;
    t_byte      r_held [MAX_PATTERN];

    logic       accept;
    logic       shift;
    t_byte      held_byte;
    t_byte      pat_byte;
    logic       byte_eq;

    assign i_in.ready = (r_state == S_IDLE) && !i_clear;
    assign accept     = i_in.valid && i_in.ready;

    // shared compare unit: held byte vs pattern byte at the scan index
    assign held_byte = r_held[r_idx[IDX_W-1:0]];
    assign pat_byte  = i_cfg.pat[r_idx[IDX_W-1:0]];
    assign byte_eq   = (held_byte == pat_byte);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_last  = r_last;
        shift   = 1'b0;
        o_req   = '0;
        o_req.last = r_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count = r_count + CNT_W'(1);
                    n_last  = i_in.content_last;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    if (r_count == i_cfg.plen) begin
                        n_count = '0;
                        n_idx   = '0;
                        n_state = S_REPL;
                    end else if (r_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (byte_eq) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    // front byte can no longer start a match
                    o_req.push  = 1'b1;
                    o_req.data  = r_held[0];
                    o_req.valid = 1'b1;
                    if (i_sts.can_push) begin
                        shift   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                        n_idx   = '0;
                    end
                end
            end
            S_REPL: begin
                if (r_idx == i_cfg.rlen) begin
                    n_state = S_FIN;
                end else begin
                    o_req.push  = 1'b1;
                    o_req.data  = i_cfg.rep[r_idx[IDX_W-1:0]];
                    o_req.valid = 1'b1;
                    if (i_sts.can_push)
                        n_idx = r_idx + CNT_W'(1);
                end
            end
            S_FLUSH: begin
                if (r_count == '0) begin
                    n_state = S_FIN;
                end else begin
                    o_req.push  = 1'b1;
                    o_req.data  = r_held[0];
                    o_req.valid = 1'b1;
                    if (i_sts.can_push) begin
                        shift   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            S_FIN: begin
                o_req.fin = 1'b1;
                if (i_sts.can_fin)
                    n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_count = '0;
            end
        endcase

        // a register write drops the held match
        if (i_clear) begin
            n_count = '0;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

    // held store: append at the count, shift toward the front on release
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held[r_count[IDX_W-1:0]] <= i_in.data_byte;
        end else if (shift) begin
            for (int k = 0; k < MAX_PATTERN - 1; k++)
                r_held[k] <= r_held[k + 1];
        end
    end

    // idle hold is always a strict prefix, so an append never overflows
    a_idle_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < i_cfg.plen))
        else $error("held count reached pattern length while idle");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index ran past held count");

    a_repl_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPL) |-> (r_count == '0))
        else $error("bytes still held while emitting replacement");

endmodule

// File: rtl/stream_find_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace-all of a configured pattern in a byte stream.
// ----------------------------------------------------------------------------
// One content byte is taken per transaction, and the block is busy until that
// byte's work is done. The held bytes are checked against the pattern one
// byte per cycle on a single comparator, unless a release waits on the
// result stage. A byte released on a mismatch leaves in the cycle of its
// failing compare, and the scan then restarts. So the number of compares is
// the held count after the append on a matching byte, and up to about 136
// when a 16-byte hold unwinds byte by byte. Results leave through a one-deep
// pending slot and an output register, so the last result of a transaction
// is tagged run_last (and stream_end on the last content byte); a last byte
// with nothing to emit yields a single marker with byte_valid low.
// Registers sit at byte address 8*i on a 64-bit APB port; any register write
// drops the held partial match.
// ----------------------------------------------------------------------------
module stream_find_replace import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    sfr_in_if.sink            i_in,
    sfr_out_if.source         o_out
);

    t_cfg      cfg;
    logic      cfg_clear;
    t_emit_req emit_req;
    t_emit_sts emit_sts;

    sfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_clear (cfg_clear)
    );

    sfr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_clear (cfg_clear),
        .i_in    (i_in),
        .o_req   (emit_req),
        .i_sts   (emit_sts)
    );

    sfr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .o_sts   (emit_sts),
        .o_out   (o_out)
    );

endmodule
